FILE: rtl/clbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package clbd_pkg;

    // Field widths fixed by the stream format
    localparam int LEVEL_W     = 10;
    localparam int LBD_W       = 11;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 16;

    // Saturation value of the distinct-level count
    localparam logic [LBD_W-1:0] LBD_MAX = {LBD_W{1'b1}};

    // Defaults for the top-level parameters
    localparam int DEF_MAX_LEVELS = 1024;
    localparam int DEF_STAMP_BITS = 32;

    // One literal as it travels from the input port into the counter
    typedef struct packed {
        logic               first;
        logic               last;
        logic               learned;
        logic               glue;
        logic [LEVEL_W-1:0] level;
    } t_lit;

endpackage
`default_nettype wire

FILE: rtl/clbd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module clbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Registered read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/clbd_clear.sv
`timescale 1ns / 1ps
`default_nettype none
module clbd_clear #(
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    output logic               o_busy,
    output logic [AW-1:0]      o_addr
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic          r_busy;
    logic [AW-1:0] r_addr;

    // Sweep every stamp entry once after reset, one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            if (r_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end
            r_addr <= r_addr + AW'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_addr;

endmodule
`default_nettype wire

FILE: rtl/clbd_count.sv
`timescale 1ns / 1ps
`default_nettype none
module clbd_count #(
    parameter int MAX_LEVELS = 1024,
    parameter int STAMP_BITS = 32,
    parameter int AW         = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_hold,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire clbd_pkg::t_lit          i_item,
    output logic                         o_rd_en,
    output logic [AW-1:0]                o_rd_addr,
    input  wire logic [STAMP_BITS-1:0]   i_rd_data,
    output logic                         o_wr_en,
    output logic [AW-1:0]                o_wr_addr,
    output logic [STAMP_BITS-1:0]        o_wr_data,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [clbd_pkg::LBD_W-1:0]   o_lbd
);

    import clbd_pkg::*;

    logic                  r_s1_valid;
    t_lit                  r_s1_item;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [LBD_W-1:0]      r_count;
    logic                  r_fwd_valid;
    logic [AW-1:0]         r_fwd_addr;
    logic [STAMP_BITS-1:0] r_fwd_data;
    logic                  r_out_valid;
    logic [LBD_W-1:0]      r_out_lbd;

    logic                  in_fire;
    logic                  s1_fire;
    logic                  counted;
    logic                  emits;
    logic                  in_range;
    logic [AW-1:0]         s1_addr;
    logic [STAMP_BITS-1:0] stored;
    logic                  hit;
    logic [LBD_W-1:0]      n_count;
    logic [STAMP_BITS-1:0] n_stamp;

    // Decode the item held in the compare stage
    assign counted  = r_s1_item.learned && !r_s1_item.glue;
    assign emits    = counted && r_s1_item.last;
    assign in_range = (32'(r_s1_item.level) < 32'(MAX_LEVELS));
    assign s1_addr  = AW'(r_s1_item.level);

    // Advance the compare stage unless its result cannot be placed
    assign s1_fire    = r_s1_valid && (!emits || !r_out_valid || i_out_ready);
    assign o_in_ready = !i_hold && (!r_s1_valid || s1_fire);
    assign in_fire    = i_in_valid && o_in_ready;

    // Issue the stamp read as the item is taken in
    assign o_rd_en   = in_fire;
    assign o_rd_addr = AW'(i_item.level);

    // Take the latest written stamp over the RAM word when addresses match
    assign stored = (r_fwd_valid && (r_fwd_addr == s1_addr)) ? r_fwd_data : i_rd_data;
    assign hit    = counted && !r_s1_item.first && in_range && (stored != r_stamp);

    // Next running stamp and count
    always_comb begin
        n_stamp = r_stamp;
        n_count = r_count;
        if (counted && r_s1_item.first) begin
            n_stamp = r_stamp + STAMP_BITS'(1);
            n_count = '0;
        end else if (hit && (r_count != LBD_MAX)) begin
            n_count = r_count + LBD_W'(1);
        end
    end

    // Mark the level with the running stamp
    assign o_wr_en   = s1_fire && hit;
    assign o_wr_addr = s1_addr;
    assign o_wr_data = r_stamp;

    // Compare stage and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_stamp     <= '0;
            r_count     <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_stamp <= n_stamp;
                r_count <= n_count;
            end
            if (o_wr_en) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_item;
        end
        if (o_wr_en) begin
            r_fwd_addr <= s1_addr;
            r_fwd_data <= r_stamp;
        end
    end

    // Result register: load on a finished clause, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && emits) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && emits) begin
            r_out_lbd <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_lbd       = r_out_lbd;

    // A stalled compare stage must block new input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |-> !o_in_ready)
        else $error("input taken while compare stage stalled");

    // A single-literal counted clause reports zero
    a_single_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && counted && r_s1_item.first && r_s1_item.last)
        |=> (r_out_valid && (r_out_lbd == '0)))
        else $error("single-literal clause gave non-zero lbd");

    // The running stamp moves only on a counted first literal
    a_stamp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_fire && counted && r_s1_item.first) |=> $stable(r_stamp))
        else $error("stamp changed without a first literal");

    // The count grows by at most one per literal
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !r_s1_item.first)
        |=> ((r_count == $past(r_count)) || (r_count == $past(r_count) + LBD_W'(1))))
        else $error("distinct count jumped");

endmodule
`default_nettype wire

FILE: rtl/clause_lbd_counter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Literal block distance counter. Literals of a clause stream in one per
// transfer with their decision level; for a learned, non-glue clause one
// result carrying the number of distinct levels among all literals but the
// first is sent after the literal marked tlast. Other clauses are passed over
// silently. One literal is taken every cycle unless a result waits untaken or
// the clearing sweep runs; each literal does one read, compare and write of
// the stamp RAM, with the last written stamp forwarded so that back-to-back
// literals on the same level count correctly. A result is registered from
// the compare stage. After reset the stamp RAM is swept to zero, tready low.
module clause_lbd_counter_top #(
    parameter int MAX_LEVELS = clbd_pkg::DEF_MAX_LEVELS,
    parameter int STAMP_BITS = clbd_pkg::DEF_STAMP_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // level [9:0], zero [15:10]
    input  wire logic [clbd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // first_literal [0], learned_clause [1], glue_clause [2]
    input  wire logic [clbd_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    input  wire logic                             i_s_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // lbd [10:0], zero [15:11]
    output logic [clbd_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    import clbd_pkg::*;

    localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    t_lit                  item;
    logic                  clr_busy;
    logic [AW-1:0]         clr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [STAMP_BITS-1:0] rd_data;
    logic                  cnt_we;
    logic [AW-1:0]         cnt_waddr;
    logic [STAMP_BITS-1:0] cnt_wdata;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [STAMP_BITS-1:0] ram_wdata;
    logic [LBD_W-1:0]      lbd;

    // Unpack the input transfer
    assign item.first   = i_s_axis_tuser[0];
    assign item.learned = i_s_axis_tuser[1];
    assign item.glue    = i_s_axis_tuser[2];
    assign item.last    = i_s_axis_tlast;
    assign item.level   = i_s_axis_tdata[LEVEL_W-1:0];

    clbd_clear #(
        .DEPTH (MAX_LEVELS),
        .AW    (AW)
    ) u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (clr_busy),
        .o_addr  (clr_addr)
    );

    // Clearing sweep owns the write port until it finishes
    assign ram_we    = clr_busy ? 1'b1     : cnt_we;
    assign ram_waddr = clr_busy ? clr_addr : cnt_waddr;
    assign ram_wdata = clr_busy ? '0       : cnt_wdata;

    clbd_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (MAX_LEVELS),
        .AW    (AW)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    clbd_count #(
        .MAX_LEVELS (MAX_LEVELS),
        .STAMP_BITS (STAMP_BITS),
        .AW         (AW)
    ) u_count (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clr_busy),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_item      (item),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (cnt_we),
        .o_wr_addr   (cnt_waddr),
        .o_wr_data   (cnt_wdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_lbd       (lbd)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'(lbd);

endmodule
`default_nettype wire
